// ===== rtl/iqq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqq_pkg
// Shared types, codes and reset values of the input event qualifier queue.
// ----------------------------------------------------------------------------
package iqq_pkg;

    localparam int IQQ_QUEUE_DEPTH = 8;
    localparam int IQQ_BTN_COUNT   = 3;

    localparam logic [2:0] REQ_SAMPLE = 3'd0;
    localparam logic [2:0] REQ_SEED   = 3'd1;
    localparam logic [2:0] REQ_ENC    = 3'd2;
    localparam logic [2:0] REQ_TOUCH  = 3'd3;
    localparam logic [2:0] REQ_POP    = 3'd4;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_BACK   = 3'd1;
    localparam logic [2:0] EV_WAKE   = 3'd2;
    localparam logic [2:0] EV_SELECT = 3'd3;
    localparam logic [2:0] EV_UP     = 3'd4;
    localparam logic [2:0] EV_DOWN   = 3'd5;

    localparam logic [1:0] BTN_BACK = 2'd0;
    localparam logic [1:0] BTN_WAKE = 2'd1;

    localparam logic [1:0] CFG_DEBOUNCE  = 2'd0;
    localparam logic [1:0] CFG_SWIPE_MIN = 2'd1;
    localparam logic [1:0] CFG_EDGE_ZONE = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST  = 16'd30;
    localparam logic [15:0] SWIPE_MIN_RST = 16'd40;
    localparam logic [15:0] EDGE_ZONE_RST = 16'd20;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_touch_res;

    function automatic logic [2:0] btn_code(input logic [1:0] id);
        logic [2:0] code;
        case (id)
            BTN_BACK: code = EV_BACK;
            BTN_WAKE: code = EV_WAKE;
            default:  code = EV_SELECT;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/iqq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module iqq_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/iqq_touch_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqq_touch_classify
// Classify a touch as tap, edge swipe right or vertical swipe.
// ----------------------------------------------------------------------------
module iqq_touch_classify
    import iqq_pkg::*;
(
    input  logic [15:0] i_start_x,
    input  logic [15:0] i_start_y,
    input  logic [15:0] i_end_x,
    input  logic [15:0] i_end_y,
    input  logic [15:0] i_swipe_min,
    input  logic [15:0] i_edge_zone,
    output t_touch_res  o_res
);

    logic        w_dx_neg;
    logic        w_dy_neg;
    logic [15:0] w_ax;
    logic [15:0] w_ay;

    assign w_dx_neg = i_end_x < i_start_x;
    assign w_dy_neg = i_end_y < i_start_y;
    assign w_ax     = w_dx_neg ? (i_start_x - i_end_x) : (i_end_x - i_start_x);
    assign w_ay     = w_dy_neg ? (i_start_y - i_end_y) : (i_end_y - i_start_y);

    always_comb begin
        o_res.hit  = 1'b0;
        o_res.code = EV_NONE;
        if ((w_ax < i_swipe_min) && (w_ay < i_swipe_min)) begin
            o_res.hit  = 1'b1;
            o_res.code = EV_SELECT;
        end else if (!w_dx_neg && (w_ax >= i_swipe_min) && (i_start_x <= i_edge_zone)
                     && (w_ax >= w_ay)) begin
            o_res.hit  = 1'b1;
            o_res.code = EV_BACK;
        end else if ((w_ay >= i_swipe_min) && (w_ay > w_ax)) begin
            o_res.hit  = 1'b1;
            o_res.code = w_dy_neg ? EV_UP : EV_DOWN;
        end
    end

endmodule

// ===== rtl/input_event_qualifier_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_event_qualifier_queue
// Button debounce, encoder and touch qualification feeding an event FIFO.
// ----------------------------------------------------------------------------
// Every accepted request yields exactly one result transaction. A request is
// held in an input register and resolved by compare logic into the result
// register once any earlier result is taken; one request is taken per cycle
// while the result side keeps up. The event codes sit in a small RAM whose
// read port is addressed with the next read pointer when a request advances,
// so a pop is served from the registered read data or from a forwarded write.
// No clearing pass is needed after reset; configuration writes are taken at
// any edge and are meant to be issued while the block is idle.
// ----------------------------------------------------------------------------
module input_event_qualifier_queue
    import iqq_pkg::*;
#(
    parameter int QUEUE_DEPTH = IQQ_QUEUE_DEPTH,
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_wdata,

    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_req_type,
    input  logic [1:0]        i_button_id,
    input  logic              i_pressed_level,
    input  logic [31:0]       i_time_ms,
    input  logic signed [15:0] i_rotary_delta,
    input  logic [15:0]       i_touch_start_x,
    input  logic [15:0]       i_touch_start_y,
    input  logic [15:0]       i_touch_end_x,
    input  logic [15:0]       i_touch_end_y,

    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_accepted,
    output logic              o_event_valid,
    output logic [2:0]        o_event_code,
    output logic [CNT_W-1:0]  o_queue_level
);

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(QUEUE_DEPTH);

    // configuration
    logic [15:0] r_debounce;
    logic [15:0] r_swipe_min;
    logic [15:0] r_edge_zone;

    // input register
    logic               r_in_valid;
    logic [2:0]         r_req;
    logic [1:0]         r_id;
    logic               r_lvl;
    logic [31:0]        r_now;
    logic signed [15:0] r_delta;
    logic [15:0]        r_sx;
    logic [15:0]        r_sy;
    logic [15:0]        r_ex;
    logic [15:0]        r_ey;

    // button state
    logic [IQQ_BTN_COUNT-1:0] r_raw;
    logic [IQQ_BTN_COUNT-1:0] n_raw;
    logic [IQQ_BTN_COUNT-1:0] r_stable;
    logic [IQQ_BTN_COUNT-1:0] n_stable;
    logic [31:0]              r_ctime [IQQ_BTN_COUNT];
    logic [31:0]              n_ctime [IQQ_BTN_COUNT];

    // queue state
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_total;
    logic [CNT_W-1:0] n_total;
    logic             r_byp_valid;
    logic [2:0]       r_byp_data;

    // result register
    logic             r_out_valid;
    logic             r_accepted;
    logic             r_event_valid;
    logic [2:0]       r_event_code;
    logic [CNT_W-1:0] r_queue_level;

    logic             w_adv;
    logic             w_in_acc;
    logic             w_id_ok;
    logic             w_full;
    logic             w_raw_cur;
    logic             w_stable_cur;
    logic [31:0]      w_ctime_cur;
    logic [31:0]      w_ctime_eff;
    logic [31:0]      w_diff;
    logic             w_hold;
    logic             w_push;
    logic [2:0]       w_push_code;
    logic             w_pop;
    logic             n_accepted;
    logic             n_event_valid;
    logic [2:0]       n_event_code;
    logic [2:0]       w_ram_rdata;
    logic [2:0]       w_head_code;
    logic [PTR_W-1:0] w_rd_addr;
    logic             w_wr_en;
    t_touch_res       w_touch;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_id_ok      = r_id < 2'(IQQ_BTN_COUNT);
    assign w_full       = r_total == CNT_FULL;
    assign w_raw_cur    = w_id_ok ? r_raw[r_id] : 1'b0;
    assign w_stable_cur = w_id_ok ? r_stable[r_id] : 1'b0;
    assign w_ctime_cur  = w_id_ok ? r_ctime[r_id] : 32'd0;
    assign w_ctime_eff  = (r_lvl != w_raw_cur) ? r_now : w_ctime_cur;
    assign w_diff       = r_now - w_ctime_eff;
    assign w_hold       = (r_lvl == w_stable_cur) || (w_diff < {16'd0, r_debounce});
    assign w_head_code  = r_byp_valid ? r_byp_data : w_ram_rdata;

    iqq_touch_classify u_touch (
        .i_start_x   (r_sx),
        .i_start_y   (r_sy),
        .i_end_x     (r_ex),
        .i_end_y     (r_ey),
        .i_swipe_min (r_swipe_min),
        .i_edge_zone (r_edge_zone),
        .o_res       (w_touch)
    );

    always_comb begin
        n_raw         = r_raw;
        n_stable      = r_stable;
        n_ctime       = r_ctime;
        w_push        = 1'b0;
        w_push_code   = EV_NONE;
        w_pop         = 1'b0;
        n_accepted    = 1'b0;
        n_event_valid = 1'b0;
        n_event_code  = EV_NONE;
        case (r_req)
            REQ_SAMPLE: begin
                if (w_id_ok) begin
                    n_raw[r_id]   = r_lvl;
                    n_ctime[r_id] = w_ctime_eff;
                    if (w_hold) begin
                        n_accepted = 1'b1;
                    end else if (!(r_lvl && w_full)) begin
                        n_accepted     = 1'b1;
                        w_push         = r_lvl;
                        w_push_code    = btn_code(r_id);
                        n_stable[r_id] = r_lvl;
                    end
                end
            end
            REQ_SEED: begin
                if (w_id_ok) begin
                    n_raw[r_id]    = r_lvl;
                    n_stable[r_id] = r_lvl;
                    n_ctime[r_id]  = r_now;
                    n_accepted     = 1'b1;
                end
            end
            REQ_ENC: begin
                if (r_delta == 16'sd0) begin
                    n_accepted = 1'b1;
                end else if (!w_full) begin
                    n_accepted  = 1'b1;
                    w_push      = 1'b1;
                    w_push_code = r_delta[15] ? EV_UP : EV_DOWN;
                end
            end
            REQ_TOUCH: begin
                if (!w_touch.hit) begin
                    n_accepted = 1'b1;
                end else if (!w_full) begin
                    n_accepted  = 1'b1;
                    w_push      = 1'b1;
                    w_push_code = w_touch.code;
                end
            end
            REQ_POP: begin
                if (r_total != '0) begin
                    w_pop         = 1'b1;
                    n_accepted    = 1'b1;
                    n_event_valid = 1'b1;
                    n_event_code  = w_head_code;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_total  = r_total;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            n_total  = r_total + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            n_total  = r_total - 1'b1;
        end
    end

    assign w_wr_en   = w_adv && w_push;
    assign w_rd_addr = !i_rst_n ? '0 : (w_adv ? n_rd_ptr : r_rd_ptr);

    iqq_ram #(
        .WIDTH (3),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (w_push_code),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DEBOUNCE_RST;
            r_swipe_min <= SWIPE_MIN_RST;
            r_edge_zone <= EDGE_ZONE_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_raw       <= '0;
            r_stable    <= '0;
            r_ctime     <= '{default: '0};
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_total     <= '0;
            r_byp_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:  r_debounce  <= i_cfg_wdata;
                    CFG_SWIPE_MIN: r_swipe_min <= i_cfg_wdata;
                    CFG_EDGE_ZONE: r_edge_zone <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_raw       <= n_raw;
                r_stable    <= n_stable;
                r_ctime     <= n_ctime;
                r_wr_ptr    <= n_wr_ptr;
                r_rd_ptr    <= n_rd_ptr;
                r_total     <= n_total;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // forward a write that lands on the address being read
            r_byp_valid <= w_wr_en && (r_wr_ptr == w_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= w_push_code;
        if (w_in_acc) begin
            r_req   <= i_req_type;
            r_id    <= i_button_id;
            r_lvl   <= i_pressed_level;
            r_now   <= i_time_ms;
            r_delta <= i_rotary_delta;
            r_sx    <= i_touch_start_x;
            r_sy    <= i_touch_start_y;
            r_ex    <= i_touch_end_x;
            r_ey    <= i_touch_end_y;
        end
        if (w_adv) begin
            r_accepted    <= n_accepted;
            r_event_valid <= n_event_valid;
            r_event_code  <= n_event_code;
            r_queue_level <= n_total;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_accepted;
    assign o_event_valid = r_event_valid;
    assign o_event_code  = r_event_code;
    assign o_queue_level = r_queue_level;

endmodule

// ===== rtl/iqq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqq_checker
// Port-level checks of the input event qualifier queue, bound to the top.
// ----------------------------------------------------------------------------
module iqq_checker
    import iqq_pkg::*;
#(
    parameter int QUEUE_DEPTH = IQQ_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_accepted,
    input logic             o_event_valid,
    input logic [2:0]       o_event_code,
    input logic [CNT_W-1:0] o_queue_level
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_code)
                                        && $stable(o_queue_level))
        else $error("result transaction dropped or changed while stalled");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> o_accepted)
        else $error("popped event without acceptance");

    a_code_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_event_code == EV_NONE)
        else $error("event code set without a popped event");

    a_level_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_queue_level <= CNT_W'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_pop_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> o_queue_level < CNT_W'(QUEUE_DEPTH))
        else $error("queue full right after a pop");

endmodule

bind input_event_qualifier_queue iqq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_iqq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_accepted    (o_accepted),
    .o_event_valid (o_event_valid),
    .o_event_code  (o_event_code),
    .o_queue_level (o_queue_level)
);
